/* rtl/byte_histogram_with_crlf_count_assert.svh */
// ----------------------------------------------------------------------------
// Byte histogram assertion macros
// Shared forms for the concurrent assertions on the histogram's ports.
// ----------------------------------------------------------------------------
`ifndef BYTE_HISTOGRAM_WITH_CRLF_COUNT_ASSERT_SVH
`define BYTE_HISTOGRAM_WITH_CRLF_COUNT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BHC_ASSERT_SAME(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BHC_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bhc_pkg.sv */
// ----------------------------------------------------------------------------
// Byte histogram package
// Item kinds, internal operation codes and the queue entry type.
// ----------------------------------------------------------------------------
package bhc_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [8:0] PAIR_INDEX = 9'd256;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;

    localparam int NUM_BINS = 256;

    typedef enum logic [2:0] {
        OP_BYTE  = 3'b001,
        OP_READ  = 3'b010,
        OP_CLEAR = 3'b100
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic [8:0] bin_index;
    } item_t;

endpackage

/* rtl/byte_histogram_with_crlf_count.sv */
// ----------------------------------------------------------------------------
// Byte histogram with CR-LF pair count
// Counts each byte value of a stream in 256 saturating bins and counts CR
// followed directly by LF. A clear word resets all counters and the previous
// byte; a read returns one bin, the pair count at index 256, or zero above it.
// ----------------------------------------------------------------------------
// The front end takes a word in any cycle its two-entry queue has room and
// drops words of the unused kind. The engine spends two steps on a data byte
// (RAM read, then saturating write-back) and two on a read word (RAM read,
// then load of the output register), so a new byte starts only after the
// last one is written back, set by the read-modify-write through the single
// bin RAM. A clear stays in the idle state: per-bin valid bits are reset at
// once, so there is no clearing pass. A read is popped from the queue with
// its RAM read, and its count is loaded into the output register in the
// execute state, which waits while the output register is still held.
module byte_histogram_with_crlf_count
    import bhc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], bin_index [16:8], zero [23:17]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // bin_count [31:0]
);

    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    bhc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    bhc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/bhc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bhc_front.sv */
// ----------------------------------------------------------------------------
// Byte histogram front end
// Accepts input words, decodes their kind and queues them for the engine.
// ----------------------------------------------------------------------------
module bhc_front
    import bhc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte [7:0], bin_index [16:8], zero [23:17]
    input  logic [1:0]  s_tuser,   // kind [1:0]
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic [0:0] wr_ptr_reg, wr_ptr_next;
    logic [0:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    item_t      item_in;

    always_comb begin
        item_in.data_byte = s_tdata[7:0];
        item_in.bin_index = s_tdata[16:8];
        item_in.op        = OP_BYTE;
        keep              = 1'b1;
        unique case (s_tuser)
            KIND_DATA:  item_in.op = OP_BYTE;
            KIND_READ:  item_in.op = OP_READ;
            KIND_CLEAR: item_in.op = OP_CLEAR;
            default:    keep = 1'b0;
        endcase
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        priority if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 2'd1;
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/bhc_back.sv */
// ----------------------------------------------------------------------------
// Byte histogram engine
// Runs queued operations against the bin RAM and drives the result channel.
// ----------------------------------------------------------------------------
module bhc_back
    import bhc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // bin_count [31:0]
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [7:0]             addr_reg;
    logic [8:0]             index_reg;
    logic [NUM_BINS-1:0]    valid_reg, valid_next;
    logic [COUNT_WIDTH-1:0] crlf_reg, crlf_next;
    logic [7:0]             prev_reg, prev_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_data_reg, m_data_next;
    logic                   load_op;

    logic                   rd_en;
    logic [7:0]             rd_addr;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] bin_now;
    logic [COUNT_WIDTH-1:0] read_val;
    logic [63:0]            read_wide;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + COUNT_WIDTH'(1);
    endfunction

    bhc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign load_op = q_pop && (q_item.op != OP_CLEAR);
    assign rd_en   = load_op;
    assign rd_addr = (q_item.op == OP_BYTE) ? q_item.data_byte : q_item.bin_index[7:0];

    assign bin_now = valid_reg[addr_reg] ? rd_data : '0;
    assign wr_data = sat_inc(bin_now);

    always_comb begin
        priority if (!index_reg[8]) begin
            read_val = bin_now;
        end else if (index_reg == PAIR_INDEX) begin
            read_val = crlf_reg;
        end else begin
            read_val = '0;
        end
        read_wide = 64'(read_val);
    end

    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        crlf_next    = crlf_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.op == OP_CLEAR) begin
                        valid_next = '0;
                        crlf_next  = '0;
                        prev_next  = '0;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_BYTE) begin
                    wr_en                = 1'b1;
                    valid_next[addr_reg] = 1'b1;
                    if (prev_reg == BYTE_CR && addr_reg == BYTE_LF) begin
                        crlf_next = sat_inc(crlf_reg);
                    end
                    prev_next  = addr_reg;
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = (|read_wide[63:32]) ? '1 : read_wide[31:0];
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            crlf_reg    <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            crlf_reg    <= crlf_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (load_op) begin
            op_reg    <= q_item.op;
            addr_reg  <= rd_addr;
            index_reg <= q_item.bin_index;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* rtl/bhc_checker.sv */
// ----------------------------------------------------------------------------
// Byte histogram port checker
// Concurrent checks on the top level's ports, attached by a bind.
// ----------------------------------------------------------------------------
`include "byte_histogram_with_crlf_count_assert.svh"

module bhc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `BHC_ASSERT_NEXT(a_reset_clears_out, 1'b0, !aresetn, !m_tvalid, "result valid after reset")
    `BHC_ASSERT_NEXT(a_reset_frees_in, 1'b0, !aresetn, s_tready, "input not ready after reset")
    `BHC_ASSERT_NEXT(a_out_held, !aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata), "stalled result changed")
    `BHC_ASSERT_SAME(a_in_ready_idle, !aresetn, !$past(aresetn), s_tready,
                     "input not ready right after reset")

endmodule

bind byte_histogram_with_crlf_count bhc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Byte histogram testbench
// Drives data, read, clear and unused-kind words into the histogram with
// random gaps on the input side and random back-pressure on the result side.
// A behavioral copy of the bins, CR-LF pair count and previous byte gives the
// expected count of each read without a typed count; each result word is
// compared in order with the oldest outstanding expectation. A short directed
// table comes first, then biased random words with many CR-LF sequences.
// ----------------------------------------------------------------------------
module testbench;
    import bhc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int DIRECTED_ROWS = 25;
    localparam int TOTAL_WORDS = 1600;
    localparam int CALM_FROM = 1400;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  octet;
        logic [8:0]  index;
        bit          has_typed;
        logic [31:0] typed_count;
    } step_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // data_byte [7:0], bin_index [16:8], zero [23:17]
    logic [1:0]  s_tuser = '0;    // kind [1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // bin_count [31:0]

    logic [31:0] octet_tally [NUM_BINS];
    logic [31:0] crlf_tally;
    logic [7:0]  last_octet;
    logic [31:0] pending_counts [$];

    step_row_t directed_rows [DIRECTED_ROWS];
    bit idling_on = 1'b1;
    int stall_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    byte_histogram_with_crlf_count dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever begin
            #2 aclk = ~aclk;
        end
    end

    function automatic logic [31:0] saturating_bump(input logic [31:0] value);
        return (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
    endfunction

    task automatic clear_profile();
        for (int i = 0; i < NUM_BINS; i++) begin
            octet_tally[i] = '0;
        end
        crlf_tally = '0;
        last_octet = '0;
    endtask

    task automatic profile_word(input logic [1:0] kind, input logic [7:0] octet,
                                input logic [8:0] index, output bit has_count,
                                output logic [31:0] count);
        has_count = 1'b0;
        count = '0;
        case (kind)
            KIND_DATA: begin
                if (last_octet == BYTE_CR && octet == BYTE_LF) begin
                    crlf_tally = saturating_bump(crlf_tally);
                end
                octet_tally[octet] = saturating_bump(octet_tally[octet]);
                last_octet = octet;
            end
            KIND_READ: begin
                has_count = 1'b1;
                if (index < NUM_BINS) begin
                    count = octet_tally[index[7:0]];
                end else if (index == PAIR_INDEX) begin
                    count = crlf_tally;
                end
            end
            KIND_CLEAR: begin
                clear_profile();
            end
            default: begin
            end
        endcase
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        $display("%0t: %s", $realtime, what);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [1:0] kind, input logic [7:0] octet,
                             input logic [8:0] index, input bit has_typed,
                             input logic [31:0] typed_count);
        int gap;
        bit has_count;
        logic [31:0] count;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'd0, index, octet};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        profile_word(kind, octet, index, has_count, count);
        if (has_count) begin
            pending_counts.push_back(has_typed ? typed_count : count);
        end
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                note_mismatch($sformatf("bin_count %h arrived with none expected", m_tdata));
            end else if (m_tdata !== pending_counts[0]) begin
                note_mismatch($sformatf("bin_count got %h, want %h",
                                        m_tdata, pending_counts[0]));
                void'(pending_counts.pop_front());
            end else begin
                void'(pending_counts.pop_front());
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("byte_histogram_with_crlf_count test failed");
        $finish;
    end

    initial begin
        int words_sent;
        int next_segment;
        int pick;
        int choice;
        logic [7:0] octet;
        logic [8:0] index;

        directed_rows[0]  = '{KIND_READ,   8'h00, 9'd0,   1'b1, 32'd0};
        directed_rows[1]  = '{KIND_READ,   8'h00, 9'd256, 1'b1, 32'd0};
        directed_rows[2]  = '{KIND_READ,   8'h00, 9'd257, 1'b1, 32'd0};
        directed_rows[3]  = '{KIND_READ,   8'hFF, 9'd511, 1'b1, 32'd0};
        directed_rows[4]  = '{KIND_DATA,   BYTE_LF, 9'd0, 1'b0, 32'd0};
        directed_rows[5]  = '{KIND_DATA,   BYTE_CR, 9'd0, 1'b0, 32'd0};
        directed_rows[6]  = '{KIND_DATA,   BYTE_LF, 9'd0, 1'b0, 32'd0};
        directed_rows[7]  = '{KIND_READ,   8'h00, 9'd256, 1'b0, 32'd0};
        directed_rows[8]  = '{KIND_DATA,   BYTE_CR, 9'd0, 1'b0, 32'd0};
        directed_rows[9]  = '{KIND_DATA,   BYTE_CR, 9'd0, 1'b0, 32'd0};
        directed_rows[10] = '{KIND_DATA,   BYTE_LF, 9'd0, 1'b0, 32'd0};
        directed_rows[11] = '{KIND_DATA,   8'h00, 9'd511, 1'b0, 32'd0};
        directed_rows[12] = '{KIND_DATA,   8'hFF, 9'd0,   1'b0, 32'd0};
        directed_rows[13] = '{KIND_UNUSED, 8'hFF, 9'd511, 1'b0, 32'd0};
        directed_rows[14] = '{KIND_READ,   8'h00, {1'b0, BYTE_CR}, 1'b0, 32'd0};
        directed_rows[15] = '{KIND_READ,   8'h00, {1'b0, BYTE_LF}, 1'b0, 32'd0};
        directed_rows[16] = '{KIND_READ,   8'h00, 9'd255, 1'b0, 32'd0};
        directed_rows[17] = '{KIND_READ,   8'h00, 9'd256, 1'b0, 32'd0};
        directed_rows[18] = '{KIND_DATA,   BYTE_CR, 9'd0, 1'b0, 32'd0};
        directed_rows[19] = '{KIND_CLEAR,  8'hFF, 9'd511, 1'b0, 32'd0};
        directed_rows[20] = '{KIND_DATA,   BYTE_LF, 9'd0, 1'b0, 32'd0};
        directed_rows[21] = '{KIND_READ,   8'h00, 9'd256, 1'b1, 32'd0};
        directed_rows[22] = '{KIND_READ,   8'h00, {1'b0, BYTE_LF}, 1'b0, 32'd0};
        directed_rows[23] = '{KIND_READ,   8'h00, {1'b0, BYTE_CR}, 1'b1, 32'd0};
        directed_rows[24] = '{KIND_READ,   8'h00, 9'd255, 1'b1, 32'd0};

        clear_profile();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        words_sent = 0;
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].kind, directed_rows[i].octet, directed_rows[i].index,
                      directed_rows[i].has_typed, directed_rows[i].typed_count);
            if (directed_rows[i].kind != KIND_UNUSED) begin
                words_sent++;
            end
        end

        next_segment = words_sent;
        while (words_sent < TOTAL_WORDS) begin
            if (words_sent >= next_segment) begin
                next_segment += 100;
                idling_on = (words_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_word(KIND_CLEAR, 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 511)), 1'b0, 32'd0);
                words_sent++;
            end else if (pick < 3) begin
                send_word(KIND_UNUSED, 8'($urandom_range(0, 255)),
                          9'($urandom_range(0, 511)), 1'b0, 32'd0);
            end else if (pick < 15) begin
                send_word(KIND_DATA, BYTE_CR, 9'($urandom_range(0, 511)), 1'b0, 32'd0);
                send_word(KIND_DATA, BYTE_LF, 9'($urandom_range(0, 511)), 1'b0, 32'd0);
                words_sent += 2;
            end else if (pick < 55) begin
                if (pick < 25) begin
                    octet = $urandom_range(0, 1) ? BYTE_CR : BYTE_LF;
                end else begin
                    octet = 8'($urandom_range(0, 255));
                end
                send_word(KIND_DATA, octet, 9'($urandom_range(0, 511)), 1'b0, 32'd0);
                words_sent++;
            end else begin
                choice = $urandom_range(0, 9);
                if (choice < 3) begin
                    index = PAIR_INDEX;
                end else if (choice == 3) begin
                    index = 9'($urandom_range(257, 511));
                end else if (choice == 4) begin
                    index = {1'b0, ($urandom_range(0, 1) ? BYTE_CR : BYTE_LF)};
                end else begin
                    index = 9'($urandom_range(0, 255));
                end
                send_word(KIND_READ, 8'($urandom_range(0, 255)), index, 1'b0, 32'd0);
                words_sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_counts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("byte_histogram_with_crlf_count test passed");
        end else begin
            $display("byte_histogram_with_crlf_count test failed");
        end
        $finish;
    end

endmodule
